// ===== src/lscle_pkg.sv =====
// Shared types, constants and a helper function for the LED strip current limit encoder.
`default_nettype none
package lscle_pkg;

    localparam int MAX_LEDS    = 48;
    localparam int END_GROUP   = 64;
    localparam int MAX_RESULTS = 62;

    localparam int IDX_W = $clog2(MAX_LEDS);
    localparam int CNT_W = $clog2(MAX_LEDS + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);
    localparam int STEP_W = 6;

    localparam logic [16:0] FULL_ONE         = 17'd65536;
    localparam logic [16:0] FACTOR_THRESHOLD = 17'd65471;
    localparam logic [12:0] LEVEL_MAX        = 13'd8191;
    localparam logic [12:0] PEAK_LOW         = 13'd8;
    localparam logic [12:0] PEAK_MID         = 13'd512;
    localparam logic [26:0] CEIL_ADD         = 27'd65535;

    localparam logic [7:0] HDR_START = 8'h00;
    localparam logic [7:0] HDR_LOW   = 8'hE1;
    localparam logic [7:0] HDR_MID   = 8'hE2;
    localparam logic [7:0] HDR_FULL  = 8'hFF;
    localparam logic [7:0] BYTE_ONES = 8'hFF;

    localparam logic [15:0] RST_TOTAL_LIMIT = 16'd20000;
    localparam logic [15:0] RST_SEG_LIMIT   = 16'd10000;
    localparam logic [5:0]  RST_SEG_SIZE    = 6'd16;

    typedef enum logic [1:0] {
        REG_TOTAL_LIMIT = 2'd0,
        REG_SEG_LIMIT   = 2'd1,
        REG_SEG_SIZE    = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_LED   = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef struct packed {
        logic [15:0] red_level;
        logic [15:0] green_level;
        logic [15:0] blue_level;
        logic        last_led;
    } t_in_word;

    typedef struct packed {
        t_kind       word_kind;
        logic [7:0]  brightness_byte;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        power_enable;
        logic        last_word;
    } t_out_word;

    typedef struct packed {
        logic              go;
        logic [STEP_W-1:0] steps;
        logic [31:0]       dividend;
        logic [15:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    // mA at full scale per channel, in tenths
    function automatic logic [7:0] cur_coef(input logic [1:0] ch);
        logic [7:0] c;
        case (ch)
            2'd0:    c = 8'd231;
            2'd1:    c = 8'd186;
            default: c = 8'd183;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/lscle_in_if.sv =====
// Input channel: one LED colour word per handshake.
`default_nettype none
interface lscle_in_if;
    logic                 valid;
    logic                 ready;
    lscle_pkg::t_in_word  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/lscle_out_if.sv =====
// Output channel: one encoded strip word per handshake.
`default_nettype none
interface lscle_out_if;
    logic                  valid;
    logic                  ready;
    lscle_pkg::t_out_word  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/lscle_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module lscle_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lscle_pkg::t_div_req i_req,
    output lscle_pkg::t_div_rsp      o_rsp
);
    logic                          r_busy;
    logic                          r_done;
    logic [lscle_pkg::STEP_W-1:0]  r_cnt;
    logic [31:0]                   r_dvd;
    logic [15:0]                   r_dvs;
    logic [15:0]                   r_rem;
    logic [31:0]                   r_quo;
    logic [16:0]                   n_trial;
    logic                          n_ge;

    assign n_trial = {r_rem, r_dvd[31]};
    assign n_ge    = n_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= n_ge ? 16'(n_trial - {1'b0, r_dvs}) : n_trial[15:0];
                r_quo <= {r_quo[30:0], n_ge};
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == lscle_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule
`default_nettype wire

// ===== src/led_strip_current_limit_encoder.sv =====
// Top level: LED frame store, current estimate, limit factor and strip word encoder.
//
//  channel | dir | handshake              | word
//  i_in    | in  | valid/ready            | three Q0.16 levels, last_led
//  o_out   | out | valid/ready, registered| kind, header, three bytes, power, last
//  config  | in  | APB write, pready high | limits and segment size at 4*i
//
// Per LED: its current (square, weight and add per channel on the shared multiplier),
// a six-step division for its segment on the shared divider, a read-modify-write of
// the segment sum and a return to idle. The last LED adds the limit factor: a
// 32-step division on the shared divider for the strip when it exceeds the total limit
// and one per full segment with current; then each LED word is emitted, scaled when
// the factor is below threshold.
// Synchronous active-low reset; a stalled output holds the sequencer at the next
// word, and input is taken only when idle.
`default_nettype none
module led_strip_current_limit_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lscle_in_if.sink         i_in,
    lscle_out_if.source      o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int IDX_W = lscle_pkg::IDX_W;
    localparam int CNT_W = lscle_pkg::CNT_W;
    localparam int RES_W = lscle_pkg::RES_W;

    typedef enum logic [20:0] {
        S_IDLE    = 21'd1,
        S_SQ      = 21'd2,
        S_WT      = 21'd4,
        S_AC      = 21'd8,
        S_SEGDIV  = 21'd16,
        S_SEGRD   = 21'd32,
        S_SEGWR   = 21'd64,
        S_FAC     = 21'd128,
        S_TDIV    = 21'd256,
        S_FULLDIV = 21'd512,
        S_SEGCHK  = 21'd1024,
        S_SEGQ    = 21'd2048,
        S_SEGDW   = 21'd4096,
        S_EMST    = 21'd8192,
        S_LRD     = 21'd16384,
        S_LSQ     = 21'd32768,
        S_LSC     = 21'd65536,
        S_LV      = 21'd131072,
        S_LST     = 21'd262144,
        S_LPUT    = 21'd524288,
        S_EMEND   = 21'd1048576
    } t_state;

    t_state                   r_state;
    logic [15:0]              r_total_limit;
    logic [15:0]              r_seg_limit;
    logic [5:0]               r_seg_size;

    logic [47:0]              colour_mem [lscle_pkg::MAX_LEDS];
    logic [15:0]              seg_mem    [lscle_pkg::MAX_LEDS];
    logic [lscle_pkg::MAX_LEDS-1:0] r_seg_vld;

    logic [15:0]              r_lvl [3];
    logic                     r_last;
    logic [1:0]               r_ch;
    logic [25:0]              r_acc;
    logic [33:0]              r_prod;
    logic [IDX_W-1:0]         r_seg_idx;
    logic [15:0]              r_seg_rd;
    logic                     r_seg_vld_rd;
    logic [15:0]              r_total;
    logic [CNT_W-1:0]         r_led_count;
    logic                     r_power;
    logic [16:0]              r_fac;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_full;
    logic [CNT_W-1:0]         r_k;
    logic [CNT_W-1:0]         r_i;
    logic [RES_W-1:0]         r_e;
    logic [47:0]              r_col;
    logic [12:0]              r_v [3];
    logic                     r_out_valid;
    lscle_pkg::t_out_word     r_out;
    lscle_pkg::t_div_req      r_div_req;
    lscle_pkg::t_div_rsp      div_rsp;

    logic                     in_acc;
    logic                     out_free;
    logic                     cfg_wr;
    logic [16:0]              m_a;
    logic [16:0]              m_b;
    logic [15:0]              lvl_sel;
    logic [15:0]              col_sel;
    logic [5:0]               seg_len;
    logic [9:0]               cur;
    logic [26:0]              cur_sum;
    logic [15:0]              seg_base;
    logic [16:0]              n_seg;
    logic [16:0]              n_total;
    logic                     scale;
    logic [IDX_W-1:0]         seg_addr;
    logic [16:0]              q_clamp;
    logic [12:0]              v_new;
    logic [12:0]              peak;
    logic [RES_W:0]           ends;
    logic [RES_W:0]           e_next;
    logic [RES_W:0]           cnt_now;
    logic                     end_last;
    lscle_pkg::t_out_word     led_word;

    lscle_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_comb begin
        case (lscle_pkg::t_reg_idx'(paddr[3:2]))
            lscle_pkg::REG_TOTAL_LIMIT: prdata = {16'd0, r_total_limit};
            lscle_pkg::REG_SEG_LIMIT:   prdata = {16'd0, r_seg_limit};
            lscle_pkg::REG_SEG_SIZE:    prdata = {26'd0, r_seg_size};
            default:                    prdata = 32'd0;
        endcase
    end

    assign seg_len = (r_seg_size == 6'd0) ? 6'd1 : r_seg_size;
    assign cur_sum = {1'b0, r_acc} + lscle_pkg::CEIL_ADD;
    assign cur     = cur_sum[25:16];
    assign seg_base = r_seg_vld_rd ? r_seg_rd : 16'd0;
    assign n_seg   = {1'b0, seg_base} + {7'd0, cur};
    assign n_total = {1'b0, r_total} + {7'd0, cur};
    assign scale   = r_power && (r_fac < lscle_pkg::FACTOR_THRESHOLD);
    assign seg_addr = (r_state == S_SEGCHK) ? r_k[IDX_W-1:0] : r_seg_idx;
    assign q_clamp = (div_rsp.quotient > 32'(lscle_pkg::FULL_ONE))
                     ? lscle_pkg::FULL_ONE : div_rsp.quotient[16:0];
    assign v_new   = (r_prod[31:16] > 16'(lscle_pkg::LEVEL_MAX))
                     ? lscle_pkg::LEVEL_MAX : r_prod[28:16];

    always_comb begin
        case (r_ch)
            2'd0:    begin lvl_sel = r_lvl[0]; col_sel = r_col[47:32]; end
            2'd1:    begin lvl_sel = r_lvl[1]; col_sel = r_col[31:16]; end
            default: begin lvl_sel = r_lvl[2]; col_sel = r_col[15:0];  end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_SQ:    begin m_a = {1'b0, lvl_sel}; m_b = {1'b0, lvl_sel}; end
            S_WT:    begin m_a = {1'b0, r_prod[31:16]};
                           m_b = {9'd0, lscle_pkg::cur_coef(r_ch)}; end
            S_LSQ:   begin m_a = {1'b0, col_sel}; m_b = {1'b0, col_sel}; end
            S_LSC:   begin m_a = {1'b0, r_prod[31:16]}; m_b = r_fac; end
            S_LV:    begin m_a = {1'b0, r_prod[31:16]};
                           m_b = {4'd0, lscle_pkg::LEVEL_MAX}; end
            default: begin m_a = 17'd0; m_b = 17'd0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // LED word header by peak channel
    always_comb begin
        peak = r_v[0];
        if (r_v[1] > peak) peak = r_v[1];
        if (r_v[2] > peak) peak = r_v[2];
        led_word.word_kind    = lscle_pkg::KIND_LED;
        led_word.power_enable = r_power;
        led_word.last_word    = 1'b0;
        if (peak < lscle_pkg::PEAK_LOW) begin
            led_word.brightness_byte = lscle_pkg::HDR_LOW;
            led_word.red_out   = r_v[0][7:0];
            led_word.green_out = r_v[1][7:0];
            led_word.blue_out  = r_v[2][7:0];
        end else if (peak < lscle_pkg::PEAK_MID) begin
            led_word.brightness_byte = lscle_pkg::HDR_MID;
            led_word.red_out   = r_v[0][8:1];
            led_word.green_out = r_v[1][8:1];
            led_word.blue_out  = r_v[2][8:1];
        end else begin
            led_word.brightness_byte = lscle_pkg::HDR_FULL;
            led_word.red_out   = r_v[0][12:5];
            led_word.green_out = r_v[1][12:5];
            led_word.blue_out  = r_v[2][12:5];
        end
    end

    assign ends     = (RES_W+1)'(r_n / lscle_pkg::END_GROUP) + (RES_W+1)'(1);
    assign e_next   = {1'b0, r_e} + (RES_W+1)'(1);
    assign cnt_now  = (RES_W+1)'(r_n) + {1'b0, r_e} + (RES_W+1)'(2);
    assign end_last = (e_next >= ends) ||
                      (cnt_now >= (RES_W+1)'(lscle_pkg::MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (in_acc && (r_led_count < CNT_W'(lscle_pkg::MAX_LEDS))) begin
            colour_mem[r_led_count[IDX_W-1:0]] <= {i_in.data.red_level,
                                                   i_in.data.green_level,
                                                   i_in.data.blue_level};
        end
        if (r_state == S_LRD) begin
            r_col <= colour_mem[r_i[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SEGWR) begin
            seg_mem[r_seg_idx] <= n_seg[16] ? 16'hFFFF : n_seg[15:0];
        end
        if ((r_state == S_SEGRD) || (r_state == S_SEGCHK)) begin
            r_seg_rd <= seg_mem[seg_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_total_limit <= lscle_pkg::RST_TOTAL_LIMIT;
            r_seg_limit   <= lscle_pkg::RST_SEG_LIMIT;
            r_seg_size    <= lscle_pkg::RST_SEG_SIZE;
            r_seg_vld     <= '0;
            r_total       <= 16'd0;
            r_led_count   <= '0;
            r_power       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_div_req.go  <= 1'b0;
        end else begin
            r_div_req.go <= 1'b0;
            if (cfg_wr) begin
                case (lscle_pkg::t_reg_idx'(paddr[3:2]))
                    lscle_pkg::REG_TOTAL_LIMIT: r_total_limit <= pwdata[15:0];
                    lscle_pkg::REG_SEG_LIMIT:   r_seg_limit   <= pwdata[15:0];
                    lscle_pkg::REG_SEG_SIZE:    r_seg_size    <= pwdata[5:0];
                    default: ;
                endcase
            end
            if (r_out_valid && o_out.ready) r_out_valid <= 1'b0;
            if ((r_state == S_SEGRD) || (r_state == S_SEGCHK)) begin
                r_seg_vld_rd <= r_seg_vld[seg_addr];
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_lvl[0] <= i_in.data.red_level;
                        r_lvl[1] <= i_in.data.green_level;
                        r_lvl[2] <= i_in.data.blue_level;
                        r_last   <= i_in.data.last_led;
                        r_acc    <= '0;
                        r_ch     <= 2'd0;
                        if (r_led_count < CNT_W'(lscle_pkg::MAX_LEDS)) r_state <= S_SQ;
                        else if (i_in.data.last_led) r_state <= S_FAC;
                    end
                end
                S_SQ: r_state <= S_WT;
                S_WT: r_state <= S_AC;
                S_AC: begin
                    r_acc <= r_acc + r_prod[25:0];
                    if (r_ch == 2'd2) begin
                        // segment index = count / segment length
                        r_div_req.go       <= 1'b1;
                        r_div_req.steps    <= lscle_pkg::STEP_W'(CNT_W);
                        r_div_req.dividend <= {r_led_count, {(32-CNT_W){1'b0}}};
                        r_div_req.divisor  <= {10'd0, seg_len};
                        r_state <= S_SEGDIV;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_SEGDIV: begin
                    if (div_rsp.done) begin
                        r_seg_idx <= div_rsp.quotient[IDX_W-1:0];
                        r_state   <= S_SEGRD;
                    end
                end
                S_SEGRD: r_state <= S_SEGWR;
                S_SEGWR: begin
                    r_seg_vld[r_seg_idx] <= 1'b1;
                    r_total     <= n_total[16] ? 16'hFFFF : n_total[15:0];
                    r_led_count <= r_led_count + CNT_W'(1);
                    r_state     <= r_last ? S_FAC : S_IDLE;
                end
                S_FAC: begin
                    r_power <= (r_total != 16'd0);
                    r_fac   <= lscle_pkg::FULL_ONE;
                    r_n     <= r_led_count;
                    if (r_total == 16'd0) begin
                        r_state <= S_EMST;
                    end else if (r_total > r_total_limit) begin
                        r_div_req.go       <= 1'b1;
                        r_div_req.steps    <= lscle_pkg::STEP_W'(32);
                        r_div_req.dividend <= {r_total_limit, 16'd0};
                        r_div_req.divisor  <= r_total;
                        r_state <= S_TDIV;
                    end else begin
                        r_div_req.go       <= 1'b1;
                        r_div_req.steps    <= lscle_pkg::STEP_W'(CNT_W);
                        r_div_req.dividend <= {r_led_count, {(32-CNT_W){1'b0}}};
                        r_div_req.divisor  <= {10'd0, seg_len};
                        r_state <= S_FULLDIV;
                    end
                end
                S_TDIV: begin
                    if (div_rsp.done) begin
                        r_fac              <= div_rsp.quotient[16:0];
                        r_div_req.go       <= 1'b1;
                        r_div_req.steps    <= lscle_pkg::STEP_W'(CNT_W);
                        r_div_req.dividend <= {r_n, {(32-CNT_W){1'b0}}};
                        r_div_req.divisor  <= {10'd0, seg_len};
                        r_state <= S_FULLDIV;
                    end
                end
                S_FULLDIV: begin
                    if (div_rsp.done) begin
                        r_full  <= div_rsp.quotient[CNT_W-1:0];
                        r_k     <= '0;
                        r_state <= S_SEGCHK;
                    end
                end
                S_SEGCHK: begin
                    if ((r_k < r_full) && (r_k < CNT_W'(lscle_pkg::MAX_LEDS)))
                        r_state <= S_SEGQ;
                    else
                        r_state <= S_EMST;
                end
                S_SEGQ: begin
                    // skip segments that never drew current
                    if (r_seg_vld_rd && (r_seg_rd != 16'd0)) begin
                        r_div_req.go       <= 1'b1;
                        r_div_req.steps    <= lscle_pkg::STEP_W'(32);
                        r_div_req.dividend <= {r_seg_limit, 16'd0};
                        r_div_req.divisor  <= r_seg_rd;
                        r_state <= S_SEGDW;
                    end else begin
                        r_k     <= r_k + CNT_W'(1);
                        r_state <= S_SEGCHK;
                    end
                end
                S_SEGDW: begin
                    if (div_rsp.done) begin
                        if (q_clamp < r_fac) r_fac <= q_clamp;
                        r_k     <= r_k + CNT_W'(1);
                        r_state <= S_SEGCHK;
                    end
                end
                S_EMST: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out <= '{word_kind: lscle_pkg::KIND_START,
                                   brightness_byte: lscle_pkg::HDR_START,
                                   red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                                   power_enable: r_power, last_word: 1'b0};
                        r_i     <= '0;
                        r_state <= S_LRD;
                    end
                end
                S_LRD: begin
                    r_ch <= 2'd0;
                    if (r_i < r_n) begin
                        r_state <= S_LSQ;
                    end else begin
                        r_e     <= '0;
                        r_state <= S_EMEND;
                    end
                end
                S_LSQ: r_state <= scale ? S_LSC : S_LV;
                S_LSC: r_state <= S_LV;
                S_LV:  r_state <= S_LST;
                S_LST: begin
                    case (r_ch)
                        2'd0:    r_v[0] <= v_new;
                        2'd1:    r_v[1] <= v_new;
                        default: r_v[2] <= v_new;
                    endcase
                    if (r_ch == 2'd2) begin
                        r_state <= S_LPUT;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= S_LSQ;
                    end
                end
                S_LPUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out   <= led_word;
                        r_i     <= r_i + CNT_W'(1);
                        r_state <= S_LRD;
                    end
                end
                S_EMEND: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out <= '{word_kind: lscle_pkg::KIND_END,
                                   brightness_byte: lscle_pkg::HDR_FULL,
                                   red_out: lscle_pkg::BYTE_ONES,
                                   green_out: lscle_pkg::BYTE_ONES,
                                   blue_out: lscle_pkg::BYTE_ONES,
                                   power_enable: r_power, last_word: end_last};
                        if (end_last) begin
                            // drop the frame's sums and count
                            r_seg_vld   <= '0;
                            r_total     <= 16'd0;
                            r_led_count <= '0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_e <= r_e + RES_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb_led_strip_current_limit_encoder.sv =====
// Self-checking testbench for the LED strip current limit encoder.
`timescale 1ns / 100ps
module tb_led_strip_current_limit_encoder;
    import lscle_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lscle_in_if  in_ch();
    lscle_out_if out_ch();

    led_strip_current_limit_encoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [15:0] led_red[MAX_LEDS];
    logic [15:0] led_grn[MAX_LEDS];
    logic [15:0] led_blu[MAX_LEDS];
    logic [15:0] seg_sum[MAX_LEDS];
    logic [15:0] strip_sum;
    int          leds_held;
    logic [15:0] lim_total;
    logic [15:0] lim_seg;
    logic [5:0]  seg_leds;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];
    int        errors;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        recv_hold;
    bit        driving;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] gamma_sq(input logic [15:0] lvl);
        logic [31:0] sq;
        sq = lvl * lvl;
        return sq >> 16;
    endfunction

    function automatic logic [31:0] led_ma(input t_in_word w);
        logic [31:0] s;
        s = gamma_sq(w.red_level) * 231 + gamma_sq(w.green_level) * 186
            + gamma_sq(w.blue_level) * 183;
        return (s + 32'd65535) >> 16;
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = a + b;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [12:0] to_level13(input logic [15:0] lvl, input bit scale,
                                               input logic [31:0] f);
        logic [63:0] g;
        logic [63:0] v;
        g = gamma_sq(lvl);
        if (scale) g = (g * f) >> 16;
        v = (g * 8191) >> 16;
        return (v > 8191) ? 13'd8191 : v[12:0];
    endfunction

    task automatic push_word(input t_kind k, input logic [7:0] hdr, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b, input bit pwr);
        t_out_word w;
        w.word_kind = k;
        w.brightness_byte = hdr;
        w.red_out = r;
        w.green_out = g;
        w.blue_out = b;
        w.power_enable = pwr;
        w.last_word = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic predict_led(input t_in_word w);
        logic [31:0] cur;
        logic [31:0] seglen;
        logic [31:0] f;
        logic [63:0] q;
        logic [12:0] v[3];
        logic [12:0] pk;
        int seg;
        int full;
        int ends;
        int cnt;
        bit pwr;
        bit scale;
        seglen = (seg_leds == 0) ? 1 : seg_leds;
        if (leds_held < MAX_LEDS) begin
            cur = led_ma(w);
            seg = leds_held / seglen;
            led_red[leds_held] = w.red_level;
            led_grn[leds_held] = w.green_level;
            led_blu[leds_held] = w.blue_level;
            seg_sum[seg] = sat16(seg_sum[seg], cur);
            strip_sum = sat16(strip_sum, cur);
            leds_held++;
        end
        if (!w.last_led) return;
        pwr = strip_sum != 0;
        f = 32'd65536;
        if (pwr) begin
            if (strip_sum > lim_total) f = ({16'd0, lim_total} << 16) / strip_sum;
            full = leds_held / seglen;
            for (int k = 0; k < full; k++) begin
                if (seg_sum[k] != 0) begin
                    q = ({48'd0, lim_seg} << 16) / seg_sum[k];
                    if (q > 65536) q = 65536;
                    if (q < f) f = q[31:0];
                end
            end
        end
        scale = pwr && f < 65471;
        push_word(KIND_START, HDR_START, 8'd0, 8'd0, 8'd0, pwr);
        for (int i = 0; i < leds_held; i++) begin
            v[0] = to_level13(led_red[i], scale, f);
            v[1] = to_level13(led_grn[i], scale, f);
            v[2] = to_level13(led_blu[i], scale, f);
            pk = v[0];
            if (v[1] > pk) pk = v[1];
            if (v[2] > pk) pk = v[2];
            if (pk < 8)
                push_word(KIND_LED, HDR_LOW, v[0][7:0], v[1][7:0], v[2][7:0], pwr);
            else if (pk < 512)
                push_word(KIND_LED, HDR_MID, 8'(v[0] / 2), 8'(v[1] / 2), 8'(v[2] / 2),
                          pwr);
            else
                push_word(KIND_LED, HDR_FULL, 8'(v[0] / 32), 8'(v[1] / 32),
                          8'(v[2] / 32), pwr);
        end
        cnt = 1 + leds_held;
        ends = leds_held / END_GROUP + 1;
        for (int i = 0; i < ends && cnt < MAX_RESULTS; i++) begin
            push_word(KIND_END, BYTE_ONES, BYTE_ONES, BYTE_ONES, BYTE_ONES, pwr);
            cnt++;
        end
        expected_words[expected_words.size() - 1].last_word = 1'b1;
        for (int k = 0; k < MAX_LEDS; k++) seg_sum[k] = '0;
        strip_sum = '0;
        leds_held = 0;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) predict_led(in_ch.data);
            if (driving && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.data  <= pending_words.pop_front();
                in_ch.valid <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word %p", $time, out_ch.data);
                    errors++;
                end else if (expected_words[0] !== out_ch.data) begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             expected_words[0], out_ch.data);
                    errors++;
                    void'(expected_words.pop_front());
                end else begin
                    void'(expected_words.pop_front());
                end
            end
            out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_in_word make_led(input logic [15:0] r, input logic [15:0] g,
                                          input logic [15:0] b, input bit last);
        t_in_word w;
        w.red_level = r;
        w.green_level = g;
        w.blue_level = b;
        w.last_led = last;
        return w;
    endfunction

    function automatic logic [15:0] rand_level();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(2000));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic queue_frame(input int n);
        for (int i = 0; i < n; i++)
            pending_words.push_back(make_led(rand_level(), rand_level(), rand_level(),
                                             i == n - 1));
    endtask

    task automatic drain();
        driving = 1'b1;
        while (pending_words.size() > 0 || in_ch.valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TOTAL_LIMIT: lim_total = val;
            REG_SEG_LIMIT:   lim_seg = val;
            default:         seg_leds = val[5:0];
        endcase
    endtask

    task automatic set_limits(input logic [15:0] t, input logic [15:0] s,
                              input logic [5:0] sz);
        apb_write(REG_TOTAL_LIMIT, t);
        apb_write(REG_SEG_LIMIT, s);
        apb_write(REG_SEG_SIZE, {10'd0, sz});
    endtask

    task automatic random_frames(input int total);
        int sent;
        sent = 0;
        while (sent < total) begin
            int n;
            n = ($urandom_range(9) == 0) ? $urandom_range(49, 56) : $urandom_range(1, 12);
            queue_frame(n);
            sent += n;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        driving = 1'b0;
        recv_hold = 1'b0;
        send_idle_pct = 8;
        recv_idle_pct = 75;
        lim_total = RST_TOTAL_LIMIT;
        lim_seg = RST_SEG_LIMIT;
        seg_leds = RST_SEG_SIZE;
        strip_sum = '0;
        leds_held = 0;
        for (int k = 0; k < MAX_LEDS; k++) seg_sum[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, dark frame, low/mid/full headers, partial segment
        pending_words.push_back(make_led(16'd0, 16'd0, 16'd0, 1'b1));
        pending_words.push_back(make_led(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        pending_words.push_back(make_led(16'd1000, 16'd0, 16'd0, 1'b0));
        pending_words.push_back(make_led(16'd0, 16'd6000, 16'd0, 1'b0));
        pending_words.push_back(make_led(16'd0, 16'd0, 16'd40000, 1'b0));
        pending_words.push_back(make_led(16'hFFFF, 16'd0, 16'd0, 1'b0));
        pending_words.push_back(make_led(16'd0, 16'hFFFF, 16'd0, 1'b0));
        pending_words.push_back(make_led(16'd0, 16'd0, 16'hFFFF, 1'b1));
        drain();
        // zero limit, segment size one, store overflow with dropped LEDs
        set_limits(16'd0, 16'd0, 6'd1);
        pending_words.push_back(make_led(16'hFFFF, 16'h8000, 16'h0001, 1'b1));
        drain();
        set_limits(16'hFFFF, 16'hFFFF, 6'd0);
        queue_frame(52);
        drain();
        set_limits(16'd300, 16'd150, 6'd60);
        queue_frame(50);
        drain();

        // random: three idling regimes, random limits between phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 75 : 0;
            recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 8 : 0;
            set_limits(16'($urandom_range(65535)), 16'($urandom_range(5000)),
                       6'($urandom_range(1, 60)));
            random_frames(25);
            drain();
            set_limits(16'($urandom_range(3000)), 16'($urandom_range(65535)),
                       6'($urandom_range(1, 8)));
            random_frames(25);
            drain();
        end

        // receiver holds off while the sender keeps offering frames
        recv_hold = 1'b1;
        queue_frame(6);
        queue_frame(4);
        queue_frame(3);
        driving = 1'b1;
        repeat (1500) @(posedge i_clk);
        recv_hold = 1'b0;
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/lscle_pkg.sv
src/lscle_in_if.sv
src/lscle_out_if.sv
src/lscle_div.sv
src/led_strip_current_limit_encoder.sv
dv/tb_led_strip_current_limit_encoder.sv
